### rtl/core/wcti_pkg.sv
// wcti_pkg: shared types and codes of the windowed chunk transfer issuer
// no dependencies; imported by every wcti module
package wcti_pkg;

  localparam int LEN_W     = 27;
  localparam int OFF_X_W   = LEN_W + 1;
  localparam int ADDR_W    = 64;
  localparam int KEY_W     = 32;
  localparam int ID_W      = 10;
  localparam int LOFF_W    = 26;
  localparam int CLEN_W    = 17;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_BURST = 16;
  localparam int CNT_W     = 5;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_COMPL = 1'b1;

  localparam logic [KIND_W-1:0] KIND_CHUNK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_LINK    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_STAGING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IO_ERROR   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_LINK_READY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGING_READY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_KEY     = 2'd2;

  typedef enum logic [1:0] {
    OP_ERROR = 2'd0,
    OP_DONE  = 2'd1,
    OP_BURST = 2'd2,
    OP_CHUNK = 2'd3
  } op_t;

  typedef struct packed {
    logic             link_ready;
    logic             staging_ready;
    logic [KEY_W-1:0] local_key;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   base;
    logic [KEY_W-1:0]    key;
    logic                dir;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    off;
  } cmd_t;

endpackage

### rtl/core/wcti_front.sv
// wcti_front: accepts items, runs the start checks and job bookkeeping
// emits at most one command per item into the queue; depends on wcti_pkg
module wcti_front #(
  parameter int CHUNK_BYTES     = 65536,
  parameter int WINDOW          = 16,
  parameter int MAX_TOTAL_BYTES = 67108864
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [wcti_pkg::ADDR_W-1:0]    in_remote_base,
  input  logic [wcti_pkg::KEY_W-1:0]     in_remote_key,
  input  logic [wcti_pkg::LEN_W-1:0]     in_total_length,
  input  logic                           in_direction,
  input  logic                           in_completion_ok,
  input  wcti_pkg::cfg_t                 cfg,
  input  logic                           q_full,
  output logic                           push,
  output wcti_pkg::cmd_t                 push_cmd
);
  import wcti_pkg::*;

  localparam int EFF_W = (WINDOW > MAX_BURST) ? MAX_BURST : WINDOW;
  localparam logic [63:0] WIN_SPAN = 64'(EFF_W) * 64'(CHUNK_BYTES);
  localparam logic [63:0] MAX_LEN  = 64'(MAX_TOTAL_BYTES);
  localparam logic [OFF_X_W-1:0] CHUNK_X = OFF_X_W'(CHUNK_BYTES);

  logic              active_r, active_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  posted_r, posted_nxt;
  logic [LEN_W-1:0]  done_off_r, done_off_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              dir_r, dir_nxt;
  logic              accept;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] off,
                                                input logic [LEN_W-1:0] lim);
    logic [OFF_X_W-1:0] sum;
    sum = {1'b0, off} + CHUNK_X;
    return (sum >= {1'b0, lim}) ? lim : sum[LEN_W-1:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    active_nxt   = active_r;
    len_nxt      = len_r;
    posted_nxt   = posted_r;
    done_off_nxt = done_off_r;
    base_nxt     = base_r;
    key_nxt      = key_r;
    dir_nxt      = dir_r;
    push         = 1'b0;
    push_cmd     = '0;
    push_cmd.op  = OP_ERROR;
    if (accept) begin
      case (in_func)
        FUNC_START: begin
          push = 1'b1;
          if (active_r) begin
            push_cmd.status = ST_BUSY;
          end else if (!cfg.link_ready) begin
            push_cmd.status = ST_NO_LINK;
          end else if (!cfg.staging_ready) begin
            push_cmd.status = ST_NO_STAGING;
          end else if (64'(in_total_length) > MAX_LEN) begin
            push_cmd.status = ST_TOO_LONG;
          end else if (in_total_length == '0) begin
            push_cmd.op     = OP_DONE;
            push_cmd.status = ST_OK;
          end else begin
            push_cmd.op   = OP_BURST;
            push_cmd.base = in_remote_base;
            push_cmd.key  = in_remote_key;
            push_cmd.dir  = in_direction;
            push_cmd.len  = in_total_length;
            active_nxt    = 1'b1;
            len_nxt       = in_total_length;
            base_nxt      = in_remote_base;
            key_nxt       = in_remote_key;
            dir_nxt       = in_direction;
            done_off_nxt  = '0;
            posted_nxt    = (64'(in_total_length) > WIN_SPAN) ?
                            WIN_SPAN[LEN_W-1:0] : in_total_length;
          end
        end
        FUNC_COMPL: begin
          if (active_r) begin
            if (!in_completion_ok) begin
              push            = 1'b1;
              push_cmd.status = ST_IO_ERROR;
              active_nxt      = 1'b0;
            end else begin
              done_off_nxt = sat_add(done_off_r, len_r);
              if (posted_r < len_r) begin
                push          = 1'b1;
                push_cmd.op   = OP_CHUNK;
                push_cmd.base = base_r;
                push_cmd.key  = key_r;
                push_cmd.dir  = dir_r;
                push_cmd.len  = len_r;
                push_cmd.off  = posted_r;
                posted_nxt    = sat_add(posted_r, len_r);
              end else if (sat_add(done_off_r, len_r) == len_r) begin
                push            = 1'b1;
                push_cmd.op     = OP_DONE;
                push_cmd.status = ST_OK;
                active_nxt      = 1'b0;
              end
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    posted_r   <= posted_nxt;
    done_off_r <= done_off_nxt;
    base_r     <= base_nxt;
    key_r      <= key_nxt;
    dir_r      <= dir_nxt;
  end

endmodule

### rtl/core/wcti_queue.sv
// wcti_queue: short command queue between front and back
// register array with head read; depends on wcti_pkg
module wcti_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wcti_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output wcti_pkg::cmd_t head,
  input  logic           pop
);
  import wcti_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/wcti_back.sv
// wcti_back: turns queued commands into results, one per cycle while not stalled
// walks start bursts chunk by chunk; depends on wcti_pkg
module wcti_back #(
  parameter int CHUNK_BYTES = 65536,
  parameter int WINDOW      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  wcti_pkg::cmd_t                    head,
  output logic                              pop,
  input  logic [wcti_pkg::KEY_W-1:0]        local_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wcti_pkg::KIND_W-1:0]       out_kind,
  output logic [wcti_pkg::STATUS_W-1:0]     out_status,
  output logic [wcti_pkg::ID_W-1:0]         out_request_id,
  output logic [wcti_pkg::ADDR_W-1:0]       out_remote_address,
  output logic [wcti_pkg::LOFF_W-1:0]       out_local_offset,
  output logic [wcti_pkg::CLEN_W-1:0]       out_chunk_length,
  output logic [wcti_pkg::KEY_W-1:0]        out_request_key,
  output logic [wcti_pkg::KEY_W-1:0]        out_staging_key,
  output logic                              out_write_dir,
  output logic                              out_last
);
  import wcti_pkg::*;

  localparam int EFF_W = (WINDOW > MAX_BURST) ? MAX_BURST : WINDOW;
  localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(EFF_W - 1);
  localparam logic [OFF_X_W-1:0] CHUNK_X  = OFF_X_W'(CHUNK_BYTES);
  localparam logic [LEN_W-1:0]   CHUNK_L  = LEN_W'(CHUNK_BYTES);

  logic                valid_r, valid_nxt;
  logic [CNT_W-1:0]    bcnt_r, bcnt_nxt;
  logic [LEN_W-1:0]    boff_r, boff_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]     rid_r, rid_nxt;
  logic [ADDR_W-1:0]   raddr_r, raddr_nxt;
  logic [LOFF_W-1:0]   loff_r, loff_nxt;
  logic [CLEN_W-1:0]   clen_r, clen_nxt;
  logic [KEY_W-1:0]    rkey_r, rkey_nxt;
  logic [KEY_W-1:0]    skey_r, skey_nxt;
  logic                wdir_r, wdir_nxt;
  logic                last_r, last_nxt;
  logic                load, fire, is_burst, fits, burst_end;
  logic [LEN_W-1:0]    cur_off, rem, clen;
  logic [ID_W-1:0]     cur_id;

  assign load      = !valid_r || !out_stall;
  assign fire      = head_valid && load;
  assign is_burst  = (head.op == OP_BURST);
  assign cur_off   = is_burst ? boff_r : head.off;
  assign cur_id    = is_burst ? ID_W'(bcnt_r) : id_r;
  assign rem       = head.len - cur_off;
  assign fits      = ({1'b0, rem} <= CHUNK_X);
  assign clen      = fits ? rem : CHUNK_L;
  assign burst_end = fits || (bcnt_r == LAST_CNT);
  assign pop       = fire && (!is_burst || burst_end);

  always_comb begin
    valid_nxt  = load ? head_valid : valid_r;
    bcnt_nxt   = bcnt_r;
    boff_nxt   = boff_r;
    id_nxt     = id_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    rid_nxt    = rid_r;
    raddr_nxt  = raddr_r;
    loff_nxt   = loff_r;
    clen_nxt   = clen_r;
    rkey_nxt   = rkey_r;
    skey_nxt   = skey_r;
    wdir_nxt   = wdir_r;
    last_nxt   = last_r;
    if (fire) begin
      kind_nxt   = KIND_ERROR;
      status_nxt = head.status;
      rid_nxt    = '0;
      raddr_nxt  = '0;
      loff_nxt   = '0;
      clen_nxt   = '0;
      rkey_nxt   = '0;
      skey_nxt   = '0;
      wdir_nxt   = 1'b0;
      last_nxt   = 1'b1;
      case (head.op)
        OP_ERROR: begin
          kind_nxt = KIND_ERROR;
        end
        OP_DONE: begin
          kind_nxt   = KIND_DONE;
          status_nxt = ST_OK;
        end
        OP_BURST, OP_CHUNK: begin
          kind_nxt   = KIND_CHUNK;
          status_nxt = ST_OK;
          rid_nxt    = cur_id;
          raddr_nxt  = head.base + ADDR_W'(cur_off);
          loff_nxt   = cur_off[LOFF_W-1:0];
          clen_nxt   = clen[CLEN_W-1:0];
          rkey_nxt   = head.key;
          skey_nxt   = local_key;
          wdir_nxt   = head.dir;
          if (is_burst) begin
            last_nxt = burst_end;
            if (burst_end) begin
              bcnt_nxt = '0;
              boff_nxt = '0;
              id_nxt   = cur_id + 1'b1;
            end else begin
              bcnt_nxt = bcnt_r + 1'b1;
              boff_nxt = boff_r + CHUNK_L;
            end
          end else begin
            id_nxt = id_r + 1'b1;
          end
        end
        default: begin
          kind_nxt = KIND_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      bcnt_r  <= '0;
      boff_r  <= '0;
      id_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      bcnt_r  <= bcnt_nxt;
      boff_r  <= boff_nxt;
      id_r    <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    raddr_r  <= raddr_nxt;
    loff_r   <= loff_nxt;
    clen_r   <= clen_nxt;
    rkey_r   <= rkey_nxt;
    skey_r   <= skey_nxt;
    wdir_r   <= wdir_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_status         = status_r;
  assign out_request_id     = rid_r;
  assign out_remote_address = raddr_r;
  assign out_local_offset   = loff_r;
  assign out_chunk_length   = clen_r;
  assign out_request_key    = rkey_r;
  assign out_staging_key    = skey_r;
  assign out_write_dir      = wdir_r;
  assign out_last           = last_r;

endmodule

### rtl/core/windowed_chunk_transfer_issuer.sv
// windowed_chunk_transfer_issuer: top level, configuration registers and wiring
// depends on wcti_pkg, wcti_front, wcti_queue, wcti_back
//
// The block takes one input item per cycle as long as its four-entry command queue
// has room, and hands out at most one result per cycle. The front classifies each
// item in the cycle it is accepted and updates the job bookkeeping at once, so
// completions can follow a start back to back. The command of an item is written
// into the queue, and the back end then registers its result from the queue head.
// A start that opens a job issues up to min(WINDOW, 16) chunk requests, fewer when
// the job has fewer chunks, one per cycle from the issue side while the output is
// not stalled; while such a burst drains the queue can fill and stall the input.
// A completion yields at most one result there. Configuration writes are always
// taken (cfg_ready is tied high).
module windowed_chunk_transfer_issuer #(
  parameter int CHUNK_BYTES     = 65536,
  parameter int WINDOW          = 16,
  parameter int MAX_TOTAL_BYTES = 67108864
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [wcti_pkg::ADDR_W-1:0]       in_remote_base,
  input  logic [wcti_pkg::KEY_W-1:0]        in_remote_key,
  input  logic [wcti_pkg::LEN_W-1:0]        in_total_length,
  input  logic                              in_direction,
  input  logic                              in_completion_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wcti_pkg::KIND_W-1:0]       out_kind,
  output logic [wcti_pkg::STATUS_W-1:0]     out_status,
  output logic [wcti_pkg::ID_W-1:0]         out_request_id,
  output logic [wcti_pkg::ADDR_W-1:0]       out_remote_address,
  output logic [wcti_pkg::LOFF_W-1:0]       out_local_offset,
  output logic [wcti_pkg::CLEN_W-1:0]       out_chunk_length,
  output logic [wcti_pkg::KEY_W-1:0]        out_request_key,
  output logic [wcti_pkg::KEY_W-1:0]        out_staging_key,
  output logic                              out_write_dir,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wcti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wcti_pkg::KEY_W-1:0]        cfg_data
);
  import wcti_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic push, q_full, head_valid, pop;
  cmd_t push_cmd, head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LINK_READY:    cfg_nxt.link_ready    = cfg_data[0];
        REG_STAGING_READY: cfg_nxt.staging_ready = cfg_data[0];
        REG_LOCAL_KEY:     cfg_nxt.local_key     = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wcti_front #(
    .CHUNK_BYTES    (CHUNK_BYTES),
    .WINDOW         (WINDOW),
    .MAX_TOTAL_BYTES(MAX_TOTAL_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_remote_base  (in_remote_base),
    .in_remote_key   (in_remote_key),
    .in_total_length (in_total_length),
    .in_direction    (in_direction),
    .in_completion_ok(in_completion_ok),
    .cfg             (cfg_r),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  wcti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  wcti_back #(
    .CHUNK_BYTES(CHUNK_BYTES),
    .WINDOW     (WINDOW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .local_key         (cfg_r.local_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_request_id    (out_request_id),
    .out_remote_address(out_remote_address),
    .out_local_offset  (out_local_offset),
    .out_chunk_length  (out_chunk_length),
    .out_request_key   (out_request_key),
    .out_staging_key   (out_staging_key),
    .out_write_dir     (out_write_dir),
    .out_last          (out_last)
  );

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for windowed_chunk_transfer_issuer
// depends on wcti_pkg and the issuer rtl; directed table, then random
// jobs checked against an in-bench model of the chunk segmenter
`timescale 1ns / 100ps

module tb_top;
  import wcti_pkg::*;

  localparam int CHUNK       = 65536;
  localparam int WIN         = 16;
  localparam int MAX_TOTAL   = 67108864;
  localparam int RAND_ITEMS  = 250;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] base;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic              dir;
    logic              ok;
  } xfer_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [ADDR_W-1:0]   raddr;
    logic [LOFF_W-1:0]   loff;
    logic [CLEN_W-1:0]   clen;
    logic [KEY_W-1:0]    rkey;
    logic [KEY_W-1:0]    skey;
    logic                wdir;
    logic                last;
  } xfer_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           rk;
    xfer_item_t          item;
    logic                typed;
    logic [KIND_W-1:0]   tkind;
    logic [STATUS_W-1:0] tstatus;
    logic [CFG_IDX_W-1:0] cidx;
    logic [KEY_W-1:0]    cdata;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_func, in_direction, in_completion_ok;
  logic [ADDR_W-1:0] in_remote_base;
  logic [KEY_W-1:0] in_remote_key;
  logic [LEN_W-1:0] in_total_length;
  logic out_valid, out_stall, out_write_dir, out_last;
  logic [KIND_W-1:0] out_kind;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0] out_request_id;
  logic [ADDR_W-1:0] out_remote_address;
  logic [LOFF_W-1:0] out_local_offset;
  logic [CLEN_W-1:0] out_chunk_length;
  logic [KEY_W-1:0] out_request_key, out_staging_key;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0] cfg_data;

  // typed expectation travelling with the driven item
  logic drv_typed;
  logic [KIND_W-1:0] drv_tkind;
  logic [STATUS_W-1:0] drv_tstatus;

  // segmenter model state
  logic m_link = 1'b0;
  logic m_stage = 1'b0;
  logic [KEY_W-1:0] m_lkey = '0;
  logic m_job_on = 1'b0;
  int unsigned m_total = 0, m_posted = 0, m_completed = 0;
  logic [LEN_W-1:0] m_len = '0;
  logic [ADDR_W-1:0] m_base = '0;
  logic [KEY_W-1:0] m_key = '0;
  logic m_dir = 1'b0;

  xfer_result_t issued_q[$];
  int err_cnt = 0;

  // sender pacing and receiver stall control
  bit idle_on;
  bit stall_on;
  bit hold_req;
  int burst_left;
  bit gen_link, gen_stage;

  windowed_chunk_transfer_issuer #(
    .CHUNK_BYTES(CHUNK),
    .WINDOW(WIN),
    .MAX_TOTAL_BYTES(MAX_TOTAL)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_remote_base(in_remote_base),
    .in_remote_key(in_remote_key),
    .in_total_length(in_total_length),
    .in_direction(in_direction),
    .in_completion_ok(in_completion_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_status(out_status),
    .out_request_id(out_request_id),
    .out_remote_address(out_remote_address),
    .out_local_offset(out_local_offset),
    .out_chunk_length(out_chunk_length),
    .out_request_key(out_request_key),
    .out_staging_key(out_staging_key),
    .out_write_dir(out_write_dir),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic close_with(logic [KIND_W-1:0] k, logic [STATUS_W-1:0] s);
    xfer_result_t r;
    r = '0;
    r.kind = k;
    r.status = s;
    issued_q.push_back(r);
  endtask

  task automatic post_chunk();
    logic [63:0] off, rest, clen;
    xfer_result_t r;
    off = 64'(m_posted) * 64'(CHUNK);
    rest = (off < 64'(m_len)) ? 64'(m_len) - off : 64'd0;
    clen = (rest < 64'(CHUNK)) ? rest : 64'(CHUNK);
    r = '0;
    r.kind = KIND_CHUNK;
    r.status = ST_OK;
    r.id = m_posted[ID_W-1:0];
    r.raddr = m_base + off;
    r.loff = off[LOFF_W-1:0];
    r.clen = clen[CLEN_W-1:0];
    r.rkey = m_key;
    r.skey = m_lkey;
    r.wdir = m_dir;
    issued_q.push_back(r);
    m_posted++;
  endtask

  task automatic segment_item(xfer_item_t it);
    int unsigned w, n0;
    n0 = issued_q.size();
    w = (WIN > MAX_BURST) ? MAX_BURST : WIN;
    if (w == 0) w = 1;
    if (it.func == FUNC_START) begin
      if (m_job_on) close_with(KIND_ERROR, ST_BUSY);
      else if (!m_link) close_with(KIND_ERROR, ST_NO_LINK);
      else if (!m_stage) close_with(KIND_ERROR, ST_NO_STAGING);
      else if (it.len > MAX_TOTAL) close_with(KIND_ERROR, ST_TOO_LONG);
      else if (it.len == 0) close_with(KIND_DONE, ST_OK);
      else begin
        m_job_on = 1'b1;
        m_len = it.len;
        m_base = it.base;
        m_key = it.key;
        m_dir = it.dir;
        m_total = (int'(it.len) + CHUNK - 1) / CHUNK;
        m_posted = 0;
        m_completed = 0;
        while (m_posted < m_total && m_posted < w) post_chunk();
      end
    end else if (m_job_on) begin
      if (!it.ok) begin
        m_job_on = 1'b0;
        close_with(KIND_ERROR, ST_IO_ERROR);
      end else begin
        m_completed++;
        if (m_posted < m_total) post_chunk();
        if (m_completed >= m_total) begin
          m_job_on = 1'b0;
          close_with(KIND_DONE, ST_OK);
        end
      end
    end
    if (issued_q.size() > n0) issued_q[$].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    xfer_item_t it;
    xfer_result_t e;
    int n0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINK_READY: m_link = cfg_data[0];
          REG_STAGING_READY: m_stage = cfg_data[0];
          REG_LOCAL_KEY: m_lkey = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        it.func = in_func;
        it.base = in_remote_base;
        it.key = in_remote_key;
        it.len = in_total_length;
        it.dir = in_direction;
        it.ok = in_completion_ok;
        n0 = issued_q.size();
        segment_item(it);
        if (drv_typed) begin
          while (issued_q.size() > n0) void'(issued_q.pop_back());
          e = '0;
          e.kind = drv_tkind;
          e.status = drv_tstatus;
          e.last = 1'b1;
          issued_q.push_back(e);
        end
      end
      if (out_valid && !out_stall) begin
        if (issued_q.size() == 0) begin
          $error("unexpected result: kind %0d status %0d", out_kind, out_status);
          err_cnt++;
        end else begin
          e = issued_q.pop_front();
          check_field("kind", 64'(e.kind), 64'(out_kind));
          check_field("status", 64'(e.status), 64'(out_status));
          check_field("request_id", 64'(e.id), 64'(out_request_id));
          check_field("remote_address", e.raddr, out_remote_address);
          check_field("local_offset", 64'(e.loff), 64'(out_local_offset));
          check_field("chunk_length", 64'(e.clen), 64'(out_chunk_length));
          check_field("request_key", 64'(e.rkey), 64'(out_request_key));
          check_field("staging_key", 64'(e.skey), 64'(out_staging_key));
          check_field("write_dir", 64'(e.wdir), 64'(out_write_dir));
          check_field("last", 64'(e.last), 64'(out_last));
        end
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int run_left;
    int hold_cnt;
    bit st;
    run_left = 0;
    hold_cnt = 0;
    st = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        out_stall = 1'b1;
        hold_cnt++;
      end else if (!stall_on) begin
        out_stall = 1'b0;
      end else begin
        if (run_left == 0) begin
          st = !st;
          run_left = st ? $urandom_range(1, 4) : $urandom_range(1, 6);
        end
        run_left--;
        out_stall = st;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic send_item(xfer_item_t it, logic typed = 1'b0,
                           logic [KIND_W-1:0] tk = KIND_CHUNK,
                           logic [STATUS_W-1:0] ts = ST_OK);
    if (burst_left == 0) begin
      if (idle_on) idle_input($urandom_range(1, 8));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_func = it.func;
    in_remote_base = it.base;
    in_remote_key = it.key;
    in_total_length = it.len;
    in_direction = it.dir;
    in_completion_ok = it.ok;
    drv_typed = typed;
    drv_tkind = tk;
    drv_tstatus = ts;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (issued_q.size() != 0) @(negedge clk);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_LINK_READY) gen_link = data[0];
    if (idx == REG_STAGING_READY) gen_stage = data[0];
  endtask

  function automatic xfer_item_t rand_item(logic f);
    xfer_item_t it;
    it.func = f;
    it.base = {$urandom, $urandom};
    it.key = $urandom;
    it.len = LEN_W'($urandom);
    it.dir = 1'($urandom_range(0, 1));
    it.ok = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic dir_row_t row_start(logic [ADDR_W-1:0] b, logic [KEY_W-1:0] k,
                                         logic [LEN_W-1:0] l, logic d, logic typed = 1'b0,
                                         logic [KIND_W-1:0] tk = KIND_CHUNK,
                                         logic [STATUS_W-1:0] ts = ST_OK);
    dir_row_t r;
    r = '0;
    r.rk = ROW_ITEM;
    r.item.func = FUNC_START;
    r.item.base = b;
    r.item.key = k;
    r.item.len = l;
    r.item.dir = d;
    r.typed = typed;
    r.tkind = tk;
    r.tstatus = ts;
    return r;
  endfunction

  function automatic dir_row_t row_compl(logic ok, logic typed = 1'b0,
                                         logic [KIND_W-1:0] tk = KIND_CHUNK,
                                         logic [STATUS_W-1:0] ts = ST_OK);
    dir_row_t r;
    r = '0;
    r.rk = ROW_ITEM;
    r.item.func = FUNC_COMPL;
    r.item.ok = ok;
    r.typed = typed;
    r.tkind = tk;
    r.tstatus = ts;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.rk = ROW_CFG;
    r.cidx = idx;
    r.cdata = data;
    return r;
  endfunction

  task automatic run_job(inout int counted);
    xfer_item_t it;
    int unsigned nch, cap;
    int r;
    bit opens;
    it = rand_item(FUNC_START);
    r = $urandom_range(0, 99);
    if (r < 6) it.len = '0;
    else if (r < 12) it.len = LEN_W'($urandom_range(MAX_TOTAL + 1, (1 << LEN_W) - 1));
    else if (r < 15) it.len = LEN_W'(MAX_TOTAL);
    else if (r < 30) it.len = LEN_W'(CHUNK * $urandom_range(1, 20));
    else if (r < 40) it.len = LEN_W'($urandom_range(1, 300));
    else it.len = LEN_W'($urandom_range(1, CHUNK * 20));
    opens = gen_link && gen_stage && it.len != 0 && it.len <= MAX_TOTAL;
    send_item(it);
    counted++;
    if (!opens) begin
      if ($urandom_range(0, 3) == 0) send_item(rand_item(FUNC_COMPL));
      return;
    end
    nch = (int'(it.len) + CHUNK - 1) / CHUNK;
    cap = (nch > 40) ? $urandom_range(0, 20) : nch;
    for (int i = 0; i < cap; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        send_item(rand_item(FUNC_START));
        counted++;
      end
      it = rand_item(FUNC_COMPL);
      if ($urandom_range(0, 99) < 2) begin
        it.ok = 1'b0;
        send_item(it);
        counted++;
        return;
      end
      it.ok = 1'b1;
      send_item(it);
      counted++;
    end
    if (cap < nch) begin
      it = rand_item(FUNC_COMPL);
      it.ok = 1'b0;
      send_item(it);
      counted++;
    end
  endtask

  initial begin
    dir_row_t tab[$];
    int counted;
    int p;
    int seqs;
    logic [KEY_W-1:0] k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_START;
    in_remote_base = '0;
    in_remote_key = '0;
    in_total_length = '0;
    in_direction = 1'b0;
    in_completion_ok = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LINK_READY;
    cfg_data = '0;
    drv_typed = 1'b0;
    drv_tkind = KIND_CHUNK;
    drv_tstatus = ST_OK;
    idle_on = 1;
    stall_on = 1;
    hold_req = 0;
    burst_left = 0;
    gen_link = 0;
    gen_stage = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tab.push_back(row_start(64'h100, 32'h1, 27'd100, 1'b0, 1'b1, KIND_ERROR, ST_NO_LINK));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_cfg(REG_LINK_READY, 32'h1));
    tab.push_back(row_start(64'h100, 32'h1, 27'd100, 1'b0, 1'b1, KIND_ERROR, ST_NO_STAGING));
    tab.push_back(row_cfg(REG_STAGING_READY, 32'hFFFF_FFFF));
    tab.push_back(row_cfg(REG_LOCAL_KEY, 32'hFFFF_FFFF));
    tab.push_back(row_cfg(REG_SPARE, 32'h0));
    tab.push_back(row_start('1, '1, 27'(MAX_TOTAL + 1), 1'b1, 1'b1, KIND_ERROR, ST_TOO_LONG));
    tab.push_back(row_start('0, '0, '1, 1'b0, 1'b1, KIND_ERROR, ST_TOO_LONG));
    tab.push_back(row_start('1, '1, '0, 1'b1, 1'b1, KIND_DONE, ST_OK));
    // second chunk address wraps past the top
    tab.push_back(row_start(64'hFFFF_FFFF_FFFF_FFF0, '1, 27'(CHUNK + 1), 1'b1));
    tab.push_back(row_start('0, '0, 27'd1, 1'b0, 1'b1, KIND_ERROR, ST_BUSY));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_start('0, '0, 27'(MAX_TOTAL), 1'b0));
    tab.push_back(row_compl(1'b0, 1'b1, KIND_ERROR, ST_IO_ERROR));
    tab.push_back(row_cfg(REG_LOCAL_KEY, 32'h0));
    tab.push_back(row_start(64'h0123_4567_89AB_CDEF, 32'h5A5A_A5A5, 27'(3 * CHUNK + 5), 1'b1));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_compl(1'b1));
    tab.push_back(row_compl(1'b1));

    foreach (tab[i]) begin
      if (tab[i].rk == ROW_CFG) begin
        quiesce();
        cfg_write(tab[i].cidx, tab[i].cdata);
      end else begin
        send_item(tab[i].item, tab[i].typed, tab[i].tkind, tab[i].tstatus);
      end
    end

    counted = 0;
    p = 0;
    while (counted < RAND_ITEMS) begin
      quiesce();
      k = $urandom;
      case (p % 6)
        0: begin gen_link = 1; gen_stage = 1; k = '0; end
        1: begin gen_link = 1; gen_stage = 1; k = '1; end
        2: begin gen_link = 0; gen_stage = 1; end
        3: begin gen_link = 1; gen_stage = 0; end
        default: begin gen_link = 1; gen_stage = 1; end
      endcase
      cfg_write(REG_LINK_READY, {31'($urandom), gen_link});
      cfg_write(REG_STAGING_READY, {31'($urandom), gen_stage});
      cfg_write(REG_LOCAL_KEY, k);
      idle_on = (p % 3 != 1);
      stall_on = (p % 4 != 2);
      seqs = (gen_link && gen_stage) ? 8 : 3;
      if (p == 0) hold_req = 1;
      for (int s = 0; s < seqs; s++) begin
        run_job(counted);
        if (p == 4 && s == 3) wait_drained();
      end
      p++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0 && issued_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/core/wcti_pkg.sv
rtl/core/wcti_front.sv
rtl/core/wcti_queue.sv
rtl/core/wcti_back.sv
rtl/core/windowed_chunk_transfer_issuer.sv
bench/tb_top.sv
